// ===== rtl/gtr_pkg.sv =====
// ----------------------------------------------------------------------------
// gtr_pkg
// shared types, constants and the 5x7 font table of the glyph text renderer
// ----------------------------------------------------------------------------
`default_nettype none

package gtr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int COLOR_BITS  = 24;
  localparam int DIM_BITS    = 13;
  localparam int GLYPH_COLS  = 5;
  localparam int GLYPH_ROWS  = 7;
  localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
  localparam int GLYPH_COUNT = 95;
  localparam int GIDX_BITS   = $clog2(GLYPH_COUNT);
  localparam int COL_BITS    = $clog2(GLYPH_COLS);
  localparam int ROW_BITS    = $clog2(GLYPH_ROWS);
  localparam int PEN_ADVANCE = 12;
  localparam int QDEPTH      = 2;
  localparam int QPTR_BITS   = $clog2(QDEPTH);
  localparam int QCNT_BITS   = QPTR_BITS + 1;

  localparam logic [7:0] CHAR_FIRST   = 8'h20;
  localparam logic [7:0] CHAR_LAST    = 8'h7E;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam logic REG_DISP_WIDTH  = 1'b0;
  localparam logic REG_DISP_HEIGHT = 1'b1;

  typedef struct packed {
    logic [COORD_BITS-1:0] pen_x;
    logic [COORD_BITS-1:0] pen_y;
    logic [COLOR_BITS-1:0] fg;
    logic [COLOR_BITS-1:0] bg;
    logic [GIDX_BITS-1:0]  gidx;
  } gtr_job_t;

  // column 0 in the lowest bits, bit 0 of a column is the top row
  function automatic logic [GLYPH_BITS-1:0] glyph_pack(
    input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
    input logic [7:0] c3, input logic [7:0] c4);
    glyph_pack = {c4[6:0], c3[6:0], c2[6:0], c1[6:0], c0[6:0]};
  endfunction

  function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [GIDX_BITS-1:0] idx);
    logic [GLYPH_BITS-1:0] g;
    unique case (idx)
      7'd0:  g = glyph_pack(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
      7'd1:  g = glyph_pack(8'h00, 8'h00, 8'h5F, 8'h00, 8'h00);
      7'd2:  g = glyph_pack(8'h00, 8'h07, 8'h00, 8'h07, 8'h00);
      7'd3:  g = glyph_pack(8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14);
      7'd4:  g = glyph_pack(8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12);
      7'd5:  g = glyph_pack(8'h23, 8'h13, 8'h08, 8'h64, 8'h62);
      7'd6:  g = glyph_pack(8'h36, 8'h49, 8'h55, 8'h22, 8'h50);
      7'd7:  g = glyph_pack(8'h00, 8'h05, 8'h03, 8'h00, 8'h00);
      7'd8:  g = glyph_pack(8'h00, 8'h1C, 8'h22, 8'h41, 8'h00);
      7'd9:  g = glyph_pack(8'h00, 8'h41, 8'h22, 8'h1C, 8'h00);
      7'd10: g = glyph_pack(8'h14, 8'h08, 8'h3E, 8'h08, 8'h14);
      7'd11: g = glyph_pack(8'h08, 8'h08, 8'h3E, 8'h08, 8'h08);
      7'd12: g = glyph_pack(8'h00, 8'h50, 8'h30, 8'h00, 8'h00);
      7'd13: g = glyph_pack(8'h08, 8'h08, 8'h08, 8'h08, 8'h08);
      7'd14: g = glyph_pack(8'h00, 8'h60, 8'h60, 8'h00, 8'h00);
      7'd15: g = glyph_pack(8'h20, 8'h10, 8'h08, 8'h04, 8'h02);
      7'd16: g = glyph_pack(8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E);
      7'd17: g = glyph_pack(8'h00, 8'h42, 8'h7F, 8'h40, 8'h00);
      7'd18: g = glyph_pack(8'h42, 8'h61, 8'h51, 8'h49, 8'h46);
      7'd19: g = glyph_pack(8'h21, 8'h41, 8'h45, 8'h4B, 8'h31);
      7'd20: g = glyph_pack(8'h18, 8'h14, 8'h12, 8'h7F, 8'h10);
      7'd21: g = glyph_pack(8'h27, 8'h45, 8'h45, 8'h45, 8'h39);
      7'd22: g = glyph_pack(8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30);
      7'd23: g = glyph_pack(8'h01, 8'h71, 8'h09, 8'h05, 8'h03);
      7'd24: g = glyph_pack(8'h36, 8'h49, 8'h49, 8'h49, 8'h36);
      7'd25: g = glyph_pack(8'h06, 8'h49, 8'h49, 8'h29, 8'h1E);
      7'd26: g = glyph_pack(8'h00, 8'h36, 8'h36, 8'h00, 8'h00);
      7'd27: g = glyph_pack(8'h00, 8'h56, 8'h36, 8'h00, 8'h00);
      7'd28: g = glyph_pack(8'h08, 8'h14, 8'h22, 8'h41, 8'h00);
      7'd29: g = glyph_pack(8'h14, 8'h14, 8'h14, 8'h14, 8'h14);
      7'd30: g = glyph_pack(8'h00, 8'h41, 8'h22, 8'h14, 8'h08);
      7'd31: g = glyph_pack(8'h02, 8'h01, 8'h51, 8'h09, 8'h06);
      7'd32: g = glyph_pack(8'h32, 8'h49, 8'h79, 8'h41, 8'h3E);
      7'd33: g = glyph_pack(8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E);
      7'd34: g = glyph_pack(8'h7F, 8'h49, 8'h49, 8'h49, 8'h36);
      7'd35: g = glyph_pack(8'h3E, 8'h41, 8'h41, 8'h41, 8'h22);
      7'd36: g = glyph_pack(8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C);
      7'd37: g = glyph_pack(8'h7F, 8'h49, 8'h49, 8'h49, 8'h41);
      7'd38: g = glyph_pack(8'h7F, 8'h09, 8'h09, 8'h09, 8'h01);
      7'd39: g = glyph_pack(8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A);
      7'd40: g = glyph_pack(8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F);
      7'd41: g = glyph_pack(8'h00, 8'h41, 8'h7F, 8'h41, 8'h00);
      7'd42: g = glyph_pack(8'h20, 8'h40, 8'h41, 8'h3F, 8'h01);
      7'd43: g = glyph_pack(8'h7F, 8'h08, 8'h14, 8'h22, 8'h41);
      7'd44: g = glyph_pack(8'h7F, 8'h40, 8'h40, 8'h40, 8'h40);
      7'd45: g = glyph_pack(8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F);
      7'd46: g = glyph_pack(8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F);
      7'd47: g = glyph_pack(8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E);
      7'd48: g = glyph_pack(8'h7F, 8'h09, 8'h09, 8'h09, 8'h06);
      7'd49: g = glyph_pack(8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E);
      7'd50: g = glyph_pack(8'h7F, 8'h09, 8'h19, 8'h29, 8'h46);
      7'd51: g = glyph_pack(8'h46, 8'h49, 8'h49, 8'h49, 8'h31);
      7'd52: g = glyph_pack(8'h01, 8'h01, 8'h7F, 8'h01, 8'h01);
      7'd53: g = glyph_pack(8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F);
      7'd54: g = glyph_pack(8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F);
      7'd55: g = glyph_pack(8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F);
      7'd56: g = glyph_pack(8'h63, 8'h14, 8'h08, 8'h14, 8'h63);
      7'd57: g = glyph_pack(8'h07, 8'h08, 8'h70, 8'h08, 8'h07);
      7'd58: g = glyph_pack(8'h61, 8'h51, 8'h49, 8'h45, 8'h43);
      7'd59: g = glyph_pack(8'h00, 8'h7F, 8'h41, 8'h41, 8'h00);
      7'd60: g = glyph_pack(8'h02, 8'h04, 8'h08, 8'h10, 8'h20);
      7'd61: g = glyph_pack(8'h00, 8'h41, 8'h41, 8'h7F, 8'h00);
      7'd62: g = glyph_pack(8'h04, 8'h02, 8'h01, 8'h02, 8'h04);
      7'd63: g = glyph_pack(8'h40, 8'h40, 8'h40, 8'h40, 8'h40);
      7'd64: g = glyph_pack(8'h00, 8'h01, 8'h02, 8'h04, 8'h00);
      7'd65: g = glyph_pack(8'h20, 8'h54, 8'h54, 8'h54, 8'h78);
      7'd66: g = glyph_pack(8'h7F, 8'h48, 8'h44, 8'h44, 8'h38);
      7'd67: g = glyph_pack(8'h38, 8'h44, 8'h44, 8'h44, 8'h20);
      7'd68: g = glyph_pack(8'h38, 8'h44, 8'h44, 8'h48, 8'h7F);
      7'd69: g = glyph_pack(8'h38, 8'h54, 8'h54, 8'h54, 8'h18);
      7'd70: g = glyph_pack(8'h08, 8'h7E, 8'h09, 8'h01, 8'h02);
      7'd71: g = glyph_pack(8'h0C, 8'h52, 8'h52, 8'h52, 8'h3E);
      7'd72: g = glyph_pack(8'h7F, 8'h08, 8'h04, 8'h04, 8'h78);
      7'd73: g = glyph_pack(8'h00, 8'h44, 8'h7D, 8'h40, 8'h00);
      7'd74: g = glyph_pack(8'h20, 8'h40, 8'h44, 8'h3D, 8'h00);
      7'd75: g = glyph_pack(8'h7F, 8'h10, 8'h28, 8'h44, 8'h00);
      7'd76: g = glyph_pack(8'h00, 8'h41, 8'h7F, 8'h40, 8'h00);
      7'd77: g = glyph_pack(8'h7C, 8'h04, 8'h18, 8'h04, 8'h78);
      7'd78: g = glyph_pack(8'h7C, 8'h08, 8'h04, 8'h04, 8'h78);
      7'd79: g = glyph_pack(8'h38, 8'h44, 8'h44, 8'h44, 8'h38);
      7'd80: g = glyph_pack(8'h7C, 8'h14, 8'h14, 8'h14, 8'h08);
      7'd81: g = glyph_pack(8'h08, 8'h14, 8'h14, 8'h18, 8'h7C);
      7'd82: g = glyph_pack(8'h7C, 8'h08, 8'h04, 8'h04, 8'h08);
      7'd83: g = glyph_pack(8'h48, 8'h54, 8'h54, 8'h54, 8'h20);
      7'd84: g = glyph_pack(8'h04, 8'h3F, 8'h44, 8'h40, 8'h20);
      7'd85: g = glyph_pack(8'h3C, 8'h40, 8'h40, 8'h20, 8'h7C);
      7'd86: g = glyph_pack(8'h1C, 8'h20, 8'h40, 8'h20, 8'h1C);
      7'd87: g = glyph_pack(8'h3C, 8'h40, 8'h30, 8'h40, 8'h3C);
      7'd88: g = glyph_pack(8'h44, 8'h28, 8'h10, 8'h28, 8'h44);
      7'd89: g = glyph_pack(8'h0C, 8'h50, 8'h50, 8'h50, 8'h3C);
      7'd90: g = glyph_pack(8'h44, 8'h64, 8'h54, 8'h4C, 8'h44);
      7'd91: g = glyph_pack(8'h00, 8'h08, 8'h36, 8'h41, 8'h00);
      7'd92: g = glyph_pack(8'h00, 8'h00, 8'h7F, 8'h00, 8'h00);
      7'd93: g = glyph_pack(8'h00, 8'h41, 8'h36, 8'h08, 8'h00);
      7'd94: g = glyph_pack(8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08);
      default: g = '0;
    endcase
    font_glyph = g;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gtr_front.sv =====
// ----------------------------------------------------------------------------
// gtr_front
// accepts character beats, tracks pen and newline stop, queues glyph jobs
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_front (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       char_code,
  input  wire logic                             string_start,
  input  wire logic [15:0]                      start_x,
  input  wire logic [15:0]                      start_y,
  input  wire logic [gtr_pkg::COLOR_BITS-1:0]   ink_rgb,
  input  wire logic [gtr_pkg::COLOR_BITS-1:0]   paper_rgb,
  input  wire logic                             q_full,
  output logic                                  q_push,
  output gtr_pkg::gtr_job_t                     q_job
);

  logic [gtr_pkg::COORD_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [gtr_pkg::COORD_BITS-1:0] pen_y_r, pen_y_nxt;
  logic                           line_ended_r, line_ended_nxt;
  logic [gtr_pkg::COORD_BITS-1:0] cur_x, cur_y;
  logic                           cur_ended;
  logic                           accept;
  logic                           printable;
  logic                           is_newline;

  assign in_ready   = !q_full;
  assign accept     = in_valid && in_ready;
  assign printable  = (char_code >= gtr_pkg::CHAR_FIRST) && (char_code <= gtr_pkg::CHAR_LAST);
  assign is_newline = (char_code == gtr_pkg::CHAR_NEWLINE);

  // string start applies before the character of the same beat
  assign cur_x     = string_start ? start_x[gtr_pkg::COORD_BITS-1:0] : pen_x_r;
  assign cur_y     = string_start ? start_y[gtr_pkg::COORD_BITS-1:0] : pen_y_r;
  assign cur_ended = string_start ? 1'b0 : line_ended_r;

  assign q_push      = accept && !cur_ended && printable;
  assign q_job.pen_x = cur_x;
  assign q_job.pen_y = cur_y;
  assign q_job.fg    = ink_rgb;
  assign q_job.bg    = paper_rgb;
  assign q_job.gidx  = gtr_pkg::GIDX_BITS'(char_code - gtr_pkg::CHAR_FIRST);

  always_comb begin
    pen_x_nxt      = cur_x;
    pen_y_nxt      = cur_y;
    line_ended_nxt = cur_ended;
    if (!cur_ended) begin
      if (is_newline) begin
        line_ended_nxt = 1'b1;
      end else if (printable) begin
        pen_x_nxt = cur_x + gtr_pkg::COORD_BITS'(gtr_pkg::PEN_ADVANCE);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      line_ended_r <= 1'b0;
    end else if (accept) begin
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      line_ended_r <= line_ended_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gtr_queue.sv =====
// ----------------------------------------------------------------------------
// gtr_queue
// short job queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire gtr_pkg::gtr_job_t  push_job,
  output logic                    full,
  input  wire logic               pop,
  output logic                    head_valid,
  output gtr_pkg::gtr_job_t       head_job
);

  gtr_pkg::gtr_job_t                 slot_r [gtr_pkg::QDEPTH];
  logic [gtr_pkg::QPTR_BITS-1:0]     wr_ptr_r;
  logic [gtr_pkg::QPTR_BITS-1:0]     rd_ptr_r;
  logic [gtr_pkg::QCNT_BITS-1:0]     cnt_r;
  logic                              do_pop;

  assign full       = (cnt_r == gtr_pkg::QCNT_BITS'(gtr_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gtr_back.sv =====
// ----------------------------------------------------------------------------
// gtr_back
// walks the 5x7 glyph cells of each job and drives the block beat register
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_back (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [gtr_pkg::DIM_BITS-1:0]     disp_width,
  input  wire logic [gtr_pkg::DIM_BITS-1:0]     disp_height,
  input  wire logic                             q_valid,
  input  wire gtr_pkg::gtr_job_t                q_job,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [15:0]                           rect_x,
  output logic [15:0]                           rect_y,
  output logic [gtr_pkg::COLOR_BITS-1:0]        rect_color,
  output logic                                  in_bounds,
  output logic                                  last_block
);

  localparam int CMP_BITS = gtr_pkg::COORD_BITS + 1;

  logic                               busy_r;
  logic [gtr_pkg::COL_BITS-1:0]       col_r;
  logic [gtr_pkg::ROW_BITS-1:0]       row_r;
  logic [gtr_pkg::GLYPH_BITS-1:0]     glyph_r;
  gtr_pkg::gtr_job_t                  job_r;
  logic                               out_valid_r;
  logic [15:0]                        rect_x_r;
  logic [15:0]                        rect_y_r;
  logic [gtr_pkg::COLOR_BITS-1:0]     rect_color_r;
  logic                               in_bounds_r;
  logic                               last_block_r;

  logic                               advance;
  logic                               emit;
  logic                               cell_last;
  logic                               row_last;
  logic [gtr_pkg::COORD_BITS-1:0]     bx, by;
  logic                               fits;

  assign advance   = !out_valid_r || out_ready;
  assign emit      = busy_r && advance;
  assign row_last  = (row_r == gtr_pkg::ROW_BITS'(gtr_pkg::GLYPH_ROWS - 1));
  assign cell_last = row_last && (col_r == gtr_pkg::COL_BITS'(gtr_pkg::GLYPH_COLS - 1));
  assign q_pop     = q_valid && (!busy_r || (emit && cell_last));

  assign bx   = job_r.pen_x + gtr_pkg::COORD_BITS'({col_r, 1'b0});
  assign by   = job_r.pen_y + gtr_pkg::COORD_BITS'({row_r, 1'b0});
  assign fits = ((CMP_BITS'(bx) + CMP_BITS'(2)) <= CMP_BITS'(disp_width)) &&
                ((CMP_BITS'(by) + CMP_BITS'(2)) <= CMP_BITS'(disp_height));

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r   <= q_job;
      glyph_r <= gtr_pkg::font_glyph(q_job.gidx);
    end else if (emit) begin
      glyph_r <= glyph_r >> 1;
    end
    if (emit) begin
      rect_x_r     <= 16'(bx);
      rect_y_r     <= 16'(by);
      rect_color_r <= glyph_r[0] ? job_r.fg : job_r.bg;
      in_bounds_r  <= fits;
      last_block_r <= cell_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (advance) begin
        out_valid_r <= busy_r;
      end
      if (q_pop) begin
        busy_r <= 1'b1;
        col_r  <= '0;
        row_r  <= '0;
      end else if (emit) begin
        if (cell_last) begin
          busy_r <= 1'b0;
        end else if (row_last) begin
          row_r <= '0;
          col_r <= col_r + 1'b1;
        end else begin
          row_r <= row_r + 1'b1;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign rect_x     = rect_x_r;
  assign rect_y     = rect_y_r;
  assign rect_color = rect_color_r;
  assign in_bounds  = in_bounds_r;
  assign last_block = last_block_r;

endmodule

`default_nettype wire

// ===== rtl/glyph_text_render.sv =====
// ----------------------------------------------------------------------------
// glyph_text_render
// 5x7 bitmap font text renderer emitting 2x2 block fill commands
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in_      in   tvalid/tready        tdata: char, start_x, start_y, fg, bg
//                                    tuser: string_start
// out_     out  tvalid/tready/tlast  tdata: rect_x, rect_y, rect_color
//                                    tuser: in_bounds, tlast: last_block
// cfg_     in   apb                  display_width @0, display_height @4
//
// a printable character on a line not ended by a newline gives 35 beats, one per
// unstalled cycle, paced by the back end's column/row walker; other codes give none
// a two-entry job queue lets the front take beats while the back is busy
// out_tready low while a beat is valid holds the output register and the walker;
// in_tready drops only while the queue is full
// synchronous reset: pen 0,0, width 800, height 480, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_text_render (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [87:0] in_tdata,   // char_code, start_x, start_y, ink_rgb, paper_rgb
  input  wire logic [0:0]  in_tuser,   // string_start
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // rect_x, rect_y, rect_color
  output logic [0:0]       out_tuser,  // in_bounds
  output logic             out_tlast,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [gtr_pkg::DIM_BITS-1:0] disp_width_r;
  logic [gtr_pkg::DIM_BITS-1:0] disp_height_r;
  logic                         cfg_wr;

  logic                         q_full;
  logic                         q_push;
  gtr_pkg::gtr_job_t            q_push_job;
  logic                         q_pop;
  logic                         q_valid;
  gtr_pkg::gtr_job_t            q_head_job;

  logic [15:0]                  rect_x;
  logic [15:0]                  rect_y;
  logic [gtr_pkg::COLOR_BITS-1:0] rect_color;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == gtr_pkg::REG_DISP_HEIGHT) ?
                      32'(disp_height_r) : 32'(disp_width_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      disp_width_r  <= gtr_pkg::DIM_BITS'(800);
      disp_height_r <= gtr_pkg::DIM_BITS'(480);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        gtr_pkg::REG_DISP_WIDTH:  disp_width_r  <= cfg_pwdata[gtr_pkg::DIM_BITS-1:0];
        gtr_pkg::REG_DISP_HEIGHT: disp_height_r <= cfg_pwdata[gtr_pkg::DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  gtr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .char_code    (in_tdata[7:0]),
    .string_start (in_tuser[0]),
    .start_x      (in_tdata[23:8]),
    .start_y      (in_tdata[39:24]),
    .ink_rgb      (in_tdata[63:40]),
    .paper_rgb    (in_tdata[87:64]),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_push_job)
  );

  gtr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (q_head_job)
  );

  gtr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .disp_width  (disp_width_r),
    .disp_height (disp_height_r),
    .q_valid     (q_valid),
    .q_job       (q_head_job),
    .q_pop       (q_pop),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .rect_x      (rect_x),
    .rect_y      (rect_y),
    .rect_color  (rect_color),
    .in_bounds   (out_tuser[0]),
    .last_block  (out_tlast)
  );

  assign out_tdata = {rect_color, rect_y, rect_x};

endmodule

`default_nettype wire

// ===== rtl/gtr_checker.sv =====
// ----------------------------------------------------------------------------
// gtr_checker
// port-level checks of the glyph text renderer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module gtr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata,
  input wire logic        out_tlast,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata
);

  // stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  // a character's blocks come without gaps
  a_char_dense: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a character");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // register read back after a write
  a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite ##1
    (cfg_psel && !cfg_pwrite && cfg_paddr[2] == $past(cfg_paddr[2]))
    |-> cfg_prdata[12:0] == $past(cfg_pwdata[12:0]) && cfg_prdata[31:13] == '0)
    else $error("register read back mismatch");

endmodule

bind glyph_text_render gtr_checker u_gtr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_tvalid  (out_tvalid),
  .out_tready  (out_tready),
  .out_tdata   (out_tdata),
  .out_tlast   (out_tlast),
  .cfg_psel    (cfg_psel),
  .cfg_penable (cfg_penable),
  .cfg_pwrite  (cfg_pwrite),
  .cfg_paddr   (cfg_paddr),
  .cfg_pwdata  (cfg_pwdata),
  .cfg_prdata  (cfg_prdata)
);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench for glyph_text_render
// drives characters into the renderer, predicts the 35 block fills each
// printable character on a line not ended by a newline gives from a private
// copy of the 5x7 font, and checks every output beat field by field; clip
// sizes are changed between runs of text while the renderer is idle, and both
// stream sides stall at random, except in the last two runs
`timescale 1ns / 100ps

module testbench;
  import gtr_pkg::*;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int SEG_ITEMS    = 60;
  localparam logic [2:0] ADDR_DISP_WIDTH  = {REG_DISP_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_DISP_HEIGHT = {REG_DISP_HEIGHT, 2'b00};

  typedef struct packed {
    logic [7:0]            code;
    logic                  start;
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COLOR_BITS-1:0] fg;
    logic [COLOR_BITS-1:0] bg;
  } char_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COLOR_BITS-1:0] color;
    logic                  inb;
    logic                  last;
  } rect_cmd_t;

  // glyph columns, column 0 in the top byte, bit 0 of a column the top row
  logic [39:0] font_cols [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h08082A1C08
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [87:0] in_tdata = '0;   // char_code, start_x, start_y, ink_rgb, paper_rgb
  logic [0:0]  in_tuser = '0;   // string_start
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;       // rect_x, rect_y, rect_color
  logic [0:0]  out_tuser;       // in_bounds
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  glyph_text_render dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  char_item_t pending_chars [$];
  rect_cmd_t  expected_rects [$];
  char_item_t cur_char;
  logic       in_fire = 1'b0;
  int         chars_queued = 0;
  int         chars_taken = 0;
  int         err_cnt = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 37;
  int         recv_idle_pct = 80;

  // renderer state as the predictor sees it
  logic [COORD_BITS-1:0] pen_x = '0;
  logic [COORD_BITS-1:0] pen_y = '0;
  logic                  line_done = 1'b0;
  logic [DIM_BITS-1:0]   disp_w = 13'd800;
  logic [DIM_BITS-1:0]   disp_h = 13'd480;

  task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h", what, want, got);
    err_cnt++;
  endtask

  task automatic render_char(input char_item_t it);
    logic [39:0] glyph;
    logic [7:0]  colbits;
    rect_cmd_t   c;
    if (it.start) begin
      pen_x = it.sx;
      pen_y = it.sy;
      line_done = 1'b0;
    end
    if (line_done) return;
    if (it.code == CHAR_NEWLINE) begin
      line_done = 1'b1;
      return;
    end
    if (it.code < CHAR_FIRST || it.code > CHAR_LAST) return;
    glyph = font_cols[it.code - CHAR_FIRST];
    for (int gx = 0; gx < GLYPH_COLS; gx++) begin
      colbits = glyph[39 - 8*gx -: 8];
      for (int gy = 0; gy < GLYPH_ROWS; gy++) begin
        c.x     = pen_x + 16'(2*gx);
        c.y     = pen_y + 16'(2*gy);
        c.color = colbits[gy] ? it.fg : it.bg;
        c.inb   = (int'(c.x) + 2 <= int'(disp_w)) && (int'(c.y) + 2 <= int'(disp_h));
        c.last  = (gx == GLYPH_COLS - 1) && (gy == GLYPH_ROWS - 1);
        expected_rects.push_back(c);
      end
    end
    pen_x = pen_x + 16'(PEN_ADVANCE);
  endtask

  task automatic check_rect();
    rect_cmd_t want;
    if (expected_rects.size() == 0) begin
      report("beat with nothing expected", '0, out_tdata[31:0]);
      return;
    end
    want = expected_rects.pop_front();
    if (out_tdata[15:0] !== want.x) report("rect_x", want.x, out_tdata[15:0]);
    if (out_tdata[31:16] !== want.y) report("rect_y", want.y, out_tdata[31:16]);
    if (out_tdata[55:32] !== want.color) report("rect_color", want.color, out_tdata[55:32]);
    if (out_tuser[0] !== want.inb) report("in_bounds", want.inb, out_tuser[0]);
    if (out_tlast !== want.last) report("last_block", want.last, out_tlast);
  endtask

  // sender: hold the beat until taken, then maybe present the next one
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_char = pending_chars.pop_front();
        in_tdata  <= {cur_char.bg, cur_char.fg, cur_char.sy, cur_char.sx, cur_char.code};
        in_tuser  <= cur_char.start;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) check_rect();
      if (in_tvalid && in_tready) begin
        render_char(cur_char);
        chars_taken++;
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = addr;
    cfg_pwdata  = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == ADDR_DISP_WIDTH) disp_w = value[DIM_BITS-1:0];
    else disp_h = value[DIM_BITS-1:0];
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
  endtask

  task automatic push_char(input logic [7:0] code, input logic start,
                           input logic [15:0] sx, input logic [15:0] sy,
                           input logic [23:0] fg, input logic [23:0] bg);
    char_item_t it;
    it.code  = code;
    it.start = start;
    it.sx    = sx;
    it.sy    = sy;
    it.fg    = fg;
    it.bg    = bg;
    pending_chars.push_back(it);
    chars_queued++;
  endtask

  task automatic wait_idle();
    while (chars_taken != chars_queued || expected_rects.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_coord(input logic [DIM_BITS-1:0] lim);
    case ($urandom_range(3))
      0: pick_coord = 16'($urandom_range(0, 15));
      1: pick_coord = 16'(lim) - 16'($urandom_range(0, 24));
      2: pick_coord = 16'($urandom);
      default: pick_coord = 16'hFFFF - 16'($urandom_range(0, 40));
    endcase
  endfunction

  // strings of random text, mostly led by a start beat, with some noise
  task automatic queue_text(input int target);
    int counted;
    int len;
    int r;
    logic [7:0] code;
    logic start;
    counted = 0;
    while (counted < target) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(99);
        if (r < 78) code = 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
        else if (r < 86) code = CHAR_NEWLINE;
        else code = 8'($urandom);
        if (k == 0) start = ($urandom_range(9) != 0);
        else start = ($urandom_range(19) == 0);
        push_char(code, start, pick_coord(disp_w), pick_coord(disp_h),
                  24'($urandom), 24'($urandom));
        if (start || code == CHAR_NEWLINE || (code >= CHAR_FIRST && code <= CHAR_LAST))
          counted++;
      end
    end
  endtask

  initial begin
    logic [31:0] seg_w [6];
    logic [31:0] seg_h [6];
    seg_w = '{32'd1, 32'd4096, 32'd0, 32'd8191, 32'($urandom_range(1, 4096)), 32'd800};
    seg_h = '{32'd1, 32'd4096, 32'd4096, 32'd0, 32'($urandom_range(1, 4096)), 32'd480};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed text against the reset clip size and pen
    push_char("A", 1'b0, 16'd500, 16'd500, 24'hFFFFFF, 24'h000000);
    push_char(" ", 1'b0, 16'd0, 16'd0, 24'h123456, 24'hABCDEF);
    push_char("~", 1'b0, 16'd0, 16'd0, 24'h000000, 24'hFFFFFF);
    push_char(8'h00, 1'b0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
    push_char(8'h1F, 1'b0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
    push_char(8'h7F, 1'b0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
    push_char(8'h80, 1'b0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
    push_char(8'hFF, 1'b0, 16'd0, 16'd0, 24'hFFFFFF, 24'hFFFFFF);
    push_char("!", 1'b0, 16'd0, 16'd0, 24'h00FF00, 24'h0000FF);
    push_char("W", 1'b1, 16'd792, 16'd468, 24'hFF0000, 24'h00FF00);
    push_char("#", 1'b1, 16'd65530, 16'd65532, 24'hA5A5A5, 24'h5A5A5A);
    push_char("@", 1'b1, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'h000000);
    push_char(CHAR_NEWLINE, 1'b0, 16'd0, 16'd0, 24'h0, 24'h0);
    push_char("C", 1'b0, 16'd0, 16'd0, 24'h111111, 24'h222222);
    push_char(CHAR_NEWLINE, 1'b1, 16'd10, 16'd10, 24'h0, 24'h0);
    push_char("D", 1'b0, 16'd0, 16'd0, 24'h333333, 24'h444444);
    push_char("E", 1'b1, 16'd0, 16'd0, 24'h555555, 24'h666666);
    push_char("H", 1'b0, 16'd0, 16'd0, 24'h777777, 24'h888888);
    push_char("i", 1'b0, 16'hFFFF, 16'hFFFF, 24'h999999, 24'hAAAAAA);
    push_char("g", 1'b1, 16'd400, 16'd478, 24'hBBBBBB, 24'hCCCCCC);
    wait_idle();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct = (seg < 2) ? 37 : (seg < 4) ? 80 : 0;
      recv_idle_pct = (seg < 2) ? 80 : (seg < 4) ? 37 : 0;
      if (seg == 5) begin
        seg_w[seg][31:DIM_BITS] = $urandom;
        seg_h[seg][31:DIM_BITS] = $urandom;
      end
      write_reg(ADDR_DISP_WIDTH, seg_w[seg]);
      write_reg(ADDR_DISP_HEIGHT, seg_h[seg]);
      queue_text(SEG_ITEMS);
      wait_idle();
    end

    if (expected_rects.size() != 0)
      report("beats never delivered", expected_rects.size(), 0);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
